// ----- src/pmsu_pkg.sv -----
`timescale 1ns / 1ps
package pmsu_pkg;
  localparam int LATTICE_SIDE_DEF = 16;
  localparam int SPIN_BITS_DEF = 8;
  localparam int TABLE_DEPTH = 27;

  typedef enum logic [1:0] {
    MODE_UPDATE = 2'd0,
    MODE_LOAD_SITE = 2'd1,
    MODE_LOAD_TABLE = 2'd2,
    MODE_NONE = 2'd3
  } mode_t;

  typedef enum logic [0:0] {
    CFG_SPIN_COUNT = 1'b0,
    CFG_ZERO_TEMP = 1'b1
  } cfg_index_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;     // latch request fields
    logic rd_center;   // issue center read
    logic rd_nbr;      // issue neighbor read (index from ctl)
    logic [4:0] nbr;   // neighbor index 0..26
    logic tally;       // compare returned data
    logic wr_prop;     // write the proposed spin
    logic decide;      // compute accept, write final
    logic wr_load;     // write load spin
    logic wr_table;    // write table entry
    logic tbl_rd;      // register table read
    logic done;        // pulse result
    logic second;      // tally into post-change count
  } cmd_t;
endpackage

// ----- src/pmsu_ctrl.sv -----
`timescale 1ns / 1ps
module pmsu_ctrl (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic [1:0] mode,
  output logic busy,
  output pmsu_pkg::cmd_t cmd
);
  typedef enum logic [7:0] {
    S_IDLE  = 8'b00000001,
    S_CTR   = 8'b00000010,
    S_PASS1 = 8'b00000100,
    S_WRP   = 8'b00001000,
    S_PASS2 = 8'b00010000,
    S_TBL   = 8'b00100000,
    S_DEC   = 8'b01000000,
    S_OUT   = 8'b10000000
  } state_t;

  state_t state, state_next;
  logic [4:0] cnt, cnt_next;
  logic [1:0] md;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt <= '0;
      md <= '0;
    end else begin
      state <= state_next;
      cnt <= cnt_next;
      if (start && !busy) md <= mode;
    end
  end

  assign busy = (state != S_IDLE);

  // neighbor reads issue for cnt 0..26; tally follows in the next cycle (cnt 1..27)
  always_comb begin
    state_next = state;
    cnt_next = cnt;
    cmd = '0;
    cmd.nbr = cnt;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_next = S_CTR;
          cnt_next = '0;
        end
      end
      S_CTR: begin
        cmd.rd_center = 1'b1;
        unique case (md)
          pmsu_pkg::MODE_UPDATE: state_next = S_PASS1;
          pmsu_pkg::MODE_LOAD_SITE: state_next = S_DEC;
          default: state_next = S_DEC;
        endcase
      end
      S_PASS1, S_PASS2: begin
        cmd.second = (state == S_PASS2);
        cmd.rd_nbr = (cnt < 5'd27);
        cmd.tally = (cnt != 5'd0);
        cnt_next = cnt + 5'd1;
        if (cnt == 5'd27) begin
          cnt_next = '0;
          state_next = (state == S_PASS1) ? S_WRP : S_TBL;
        end
      end
      S_WRP: begin
        cmd.wr_prop = 1'b1;
        state_next = S_PASS2;
      end
      S_TBL: begin
        cmd.tbl_rd = 1'b1;
        state_next = S_DEC;
      end
      S_DEC: begin
        unique case (md)
          pmsu_pkg::MODE_UPDATE: cmd.decide = 1'b1;
          pmsu_pkg::MODE_LOAD_SITE: cmd.wr_load = 1'b1;
          pmsu_pkg::MODE_LOAD_TABLE: cmd.wr_table = 1'b1;
          default: ;
        endcase
        state_next = S_OUT;
      end
      S_OUT: begin
        cmd.done = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule

// ----- src/pmsu_datapath.sv -----
`timescale 1ns / 1ps
module pmsu_datapath #(
  parameter int LATTICE_SIDE = pmsu_pkg::LATTICE_SIDE_DEF,
  parameter int SPIN_BITS = pmsu_pkg::SPIN_BITS_DEF
) (
  input  logic clk,
  input  pmsu_pkg::cmd_t cmd,
  input  logic [1:0] mode,
  input  logic [3:0] site_x,
  input  logic [3:0] site_y,
  input  logic [3:0] site_z,
  input  logic [15:0] uniform_spin,
  input  logic [15:0] uniform_accept,
  input  logic [4:0] table_index,
  input  logic [15:0] load_value,
  input  logic [7:0] spin_count,
  input  logic zero_temperature,
  output logic [7:0] old_spin,
  output logic [7:0] new_spin,
  output logic accepted,
  output logic signed [5:0] energy_change
);
  localparam int CW = $clog2(LATTICE_SIDE);
  localparam int AW = 3 * CW;
  // each axis gets a power-of-two slot so the address is a plain concatenation
  localparam int SITES = 1 << AW;

  logic [SPIN_BITS-1:0] lattice [SITES];
  logic [15:0] btable [pmsu_pkg::TABLE_DEPTH];

  logic [1:0] md;
  logic [CW-1:0] cx, cy, cz;
  logic [15:0] ua, lv;
  logic [4:0] ti;
  logic [SPIN_BITS-1:0] center, prop, rdata;
  logic [4:0] e0, e1;
  logic [15:0] tval;
  logic [23:0] prod;
  logic [8:0] praw;
  logic [7:0] pcl;

  // coordinates reduced modulo side (side need not be a power of two)
  function automatic logic [CW-1:0] wrapc(input logic [3:0] v);
    logic [7:0] t;
    t = {4'd0, v};
    for (int i = 0; i < 4; i++) begin
      if (t >= 8'(LATTICE_SIDE)) t = t - 8'(LATTICE_SIDE);
    end
    return t[CW-1:0];
  endfunction

  function automatic logic [CW-1:0] step(input logic [CW-1:0] c, input logic [1:0] d);
    logic [CW:0] s;
    s = {1'b0, c} + {{(CW-1){1'b0}}, d} + (CW+1)'(LATTICE_SIDE - 1);
    if (s >= (CW+1)'(LATTICE_SIDE)) s = s - (CW+1)'(LATTICE_SIDE);
    if (s >= (CW+1)'(LATTICE_SIDE)) s = s - (CW+1)'(LATTICE_SIDE);
    return s[CW-1:0];
  endfunction

  logic [1:0] dx, dy, dz;
  logic [4:0] r9;
  logic [AW-1:0] raddr, caddr;
  // neighbor index split into base-3 digits by compare and subtract
  always_comb begin
    dx = (cmd.nbr >= 5'd18) ? 2'd2 : ((cmd.nbr >= 5'd9) ? 2'd1 : 2'd0);
    r9 = cmd.nbr - ((cmd.nbr >= 5'd18) ? 5'd18 : ((cmd.nbr >= 5'd9) ? 5'd9 : 5'd0));
    dy = (r9 >= 5'd6) ? 2'd2 : ((r9 >= 5'd3) ? 2'd1 : 2'd0);
    dz = 2'(r9 - ((r9 >= 5'd6) ? 5'd6 : ((r9 >= 5'd3) ? 5'd3 : 5'd0)));
    caddr = {cx, cy, cz};
    raddr = cmd.rd_nbr ? {step(cx, dx), step(cy, dy), step(cz, dz)} : caddr;
  end

  assign prod = 24'(spin_count) * 24'(uniform_spin);
  always_comb begin
    praw = 9'(prod[23:16]) + 9'd1;
    pcl = (praw > {1'b0, spin_count}) ? spin_count : praw[7:0];
  end

  logic signed [5:0] de;
  assign de = $signed({1'b0, e1}) - $signed({1'b0, e0});

  always_ff @(posedge clk) begin
    rdata <= lattice[raddr];
    if (cmd.capture) begin
      md <= mode;
      cx <= wrapc(site_x);
      cy <= wrapc(site_y);
      cz <= wrapc(site_z);
      ua <= uniform_accept;
      ti <= table_index;
      lv <= load_value;
      prop <= SPIN_BITS'(pcl);
      e0 <= '0;
      e1 <= '0;
    end
    if (cmd.rd_center) center <= lattice[caddr];
    if (cmd.tally && (rdata != (cmd.second ? prop : center))) begin
      if (cmd.second) e1 <= e1 + 5'd1;
      else e0 <= e0 + 5'd1;
    end
    if (cmd.wr_prop) lattice[caddr] <= prop;
    if (cmd.tbl_rd) tval <= btable[de[4:0]];
    if (cmd.wr_table && ti < 5'(pmsu_pkg::TABLE_DEPTH)) btable[ti] <= lv;
    if (cmd.wr_load) lattice[caddr] <= lv[SPIN_BITS-1:0];
    if (cmd.decide) begin
      logic acc;
      acc = (de <= 0) ? 1'b1 : (zero_temperature ? 1'b0 : (ua <= tval));
      if (!acc) lattice[caddr] <= center;
      old_spin <= 8'(center);
      new_spin <= acc ? 8'(prop) : 8'(center);
      accepted <= acc;
      energy_change <= de;
    end
    if (cmd.wr_load) begin
      old_spin <= 8'(center);
      new_spin <= 8'(lv[SPIN_BITS-1:0]);
      accepted <= 1'b0;
      energy_change <= '0;
    end
    if ((cmd.wr_table || (!cmd.decide && !cmd.wr_load && !cmd.done && !cmd.capture
        && md[1] && !cmd.rd_center && !cmd.tally && !cmd.rd_nbr))) begin
      old_spin <= '0;
      new_spin <= '0;
      accepted <= 1'b0;
      energy_change <= '0;
    end
  end
endmodule

// ----- src/potts_metropolis_site_update_unit.sv -----
`timescale 1ns / 1ps
// Update: center read, neighbor pass on the lattice memory, proposed-spin write,
// second neighbor pass, table read, decide, then done.
// Loads skip the neighbor passes. One request at a time; the next start after done.
// Results show for one cycle with done; the receiver cannot stall.
// Synchronous active-high reset resets control and config to defaults; memories undefined.
module potts_metropolis_site_update_unit #(
  parameter int LATTICE_SIDE = pmsu_pkg::LATTICE_SIDE_DEF,
  parameter int SPIN_BITS = pmsu_pkg::SPIN_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  logic [1:0] mode,
  input  logic [3:0] site_x,
  input  logic [3:0] site_y,
  input  logic [3:0] site_z,
  input  logic [15:0] uniform_spin,
  input  logic [15:0] uniform_accept,
  input  logic [4:0] table_index,
  input  logic [15:0] load_value,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [0:0] cfg_index,
  input  logic [7:0] cfg_data,
  output logic done,
  output logic [7:0] old_spin,
  output logic [7:0] new_spin,
  output logic accepted,
  output logic signed [5:0] energy_change
);
  pmsu_pkg::cmd_t cmd;
  logic [7:0] spin_count;
  logic zero_temperature;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      spin_count <= 8'd2;
      zero_temperature <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= cmd.done;
      if (cfg_valid) begin
        unique case (cfg_index)
          pmsu_pkg::CFG_SPIN_COUNT: spin_count <= cfg_data;
          pmsu_pkg::CFG_ZERO_TEMP: zero_temperature <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  pmsu_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .mode(mode), .busy(busy), .cmd(cmd)
  );

  pmsu_datapath #(.LATTICE_SIDE(LATTICE_SIDE), .SPIN_BITS(SPIN_BITS)) u_dp (
    .clk(clk), .cmd(cmd), .mode(mode), .site_x(site_x), .site_y(site_y),
    .site_z(site_z), .uniform_spin(uniform_spin), .uniform_accept(uniform_accept),
    .table_index(table_index), .load_value(load_value), .spin_count(spin_count),
    .zero_temperature(zero_temperature), .old_spin(old_spin), .new_spin(new_spin),
    .accepted(accepted), .energy_change(energy_change)
  );
endmodule

// ----- src/pmsu_checker.sv -----
`timescale 1ns / 1ps
module pmsu_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done,
  input logic accepted,
  input logic [7:0] old_spin,
  input logic [7:0] new_spin,
  input logic signed [5:0] energy_change
);
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("request not taken");
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("done while busy");
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("done held");
  a_reject: assert property (@(posedge clk) disable iff (rst)
    done && !accepted && energy_change != 0 |-> new_spin == old_spin)
    else $error("rejected change kept");
endmodule

bind potts_metropolis_site_update_unit pmsu_checker u_chk (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done),
  .accepted(accepted), .old_spin(old_spin), .new_spin(new_spin),
  .energy_change(energy_change)
);

// ----- dv/potts_metropolis_site_update_unit_test.sv -----
`timescale 1ns / 1ps
module potts_metropolis_site_update_unit_test;
  localparam int SIDE = 16;
  localparam int SITES = SIDE * SIDE * SIDE;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int DRAIN_CYCLES = 80;
  // updates stay on coordinates 15..3; their neighborhoods span 14..4
  localparam int FILL_SPAN = 7;

  typedef struct {
    pmsu_pkg::mode_t mode;
    logic [3:0] x, y, z;
    logic [15:0] u_spin, u_acc;
    logic [4:0] tidx;
    logic [15:0] load;
  } site_request_t;

  typedef struct {
    logic [7:0] old_spin, new_spin;
    logic accepted;
    logic signed [5:0] energy_change;
  } site_outcome_t;

  logic clk = 0;
  logic rst = 1;
  logic start = 0;
  logic busy;
  logic [1:0] mode = '0;
  logic [3:0] site_x = '0, site_y = '0, site_z = '0;
  logic [15:0] uniform_spin = '0, uniform_accept = '0, load_value = '0;
  logic [4:0] table_index = '0;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [0:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;
  logic done;
  logic [7:0] old_spin, new_spin;
  logic accepted;
  logic signed [5:0] energy_change;

  // shadow state
  logic [7:0] lattice_copy [SITES];
  logic [15:0] boltz_copy [pmsu_pkg::TABLE_DEPTH];
  logic [7:0] spin_count_copy;
  logic zero_temp_copy;

  site_outcome_t pending_results[$];
  int errors = 0;
  int cycles = 0;
  bit gaps_on = 1;

  potts_metropolis_site_update_unit DUT (.*);

  always #5 clk = ~clk;

  function automatic int site_addr(logic [3:0] x, logic [3:0] y, logic [3:0] z);
    return (int'(x) * SIDE + int'(y)) * SIDE + int'(z);
  endfunction

  function automatic int unlike_neighbors(logic [3:0] x, logic [3:0] y, logic [3:0] z);
    int n;
    logic [7:0] c;
    n = 0;
    c = lattice_copy[site_addr(x, y, z)];
    for (int dx = -1; dx <= 1; dx++)
      for (int dy = -1; dy <= 1; dy++)
        for (int dz = -1; dz <= 1; dz++)
          if (lattice_copy[site_addr(4'(x + dx), 4'(y + dy), 4'(z + dz))] != c) n++;
    return n;
  endfunction

  function automatic site_outcome_t predict_site_update(site_request_t r);
    site_outcome_t o;
    int a, e0, e1, de;
    int unsigned prop;
    o = '{default: '0};
    a = site_addr(r.x, r.y, r.z);
    case (r.mode)
      pmsu_pkg::MODE_UPDATE: begin
        o.old_spin = lattice_copy[a];
        e0 = unlike_neighbors(r.x, r.y, r.z);
        prop = ((int'(spin_count_copy) * int'(r.u_spin)) >> 16) + 1;
        if (prop > spin_count_copy) prop = spin_count_copy;
        lattice_copy[a] = prop[7:0];
        e1 = unlike_neighbors(r.x, r.y, r.z);
        de = e1 - e0;
        if (de <= 0) o.accepted = 1;
        else if (zero_temp_copy) o.accepted = 0;
        else o.accepted = (r.u_acc <= boltz_copy[de]);
        if (!o.accepted) lattice_copy[a] = o.old_spin;
        o.new_spin = lattice_copy[a];
        o.energy_change = 6'(de);
      end
      pmsu_pkg::MODE_LOAD_SITE: begin
        o.old_spin = lattice_copy[a];
        lattice_copy[a] = r.load[7:0];
        o.new_spin = lattice_copy[a];
      end
      pmsu_pkg::MODE_LOAD_TABLE: begin
        if (r.tidx < pmsu_pkg::TABLE_DEPTH) boltz_copy[r.tidx] = r.load;
      end
      default: ;
    endcase
    return o;
  endfunction

  task automatic report_mismatch(string msg);
    $display("mismatch @%0t: %s", $realtime, msg);
    errors++;
  endtask

  // start stays high between back-to-back requests; only one NBA per step
  task automatic send_request(site_request_t r);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      start <= 0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    start <= 1;
    mode <= r.mode;
    site_x <= r.x; site_y <= r.y; site_z <= r.z;
    uniform_spin <= r.u_spin; uniform_accept <= r.u_acc;
    table_index <= r.tidx; load_value <= r.load;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_results.push_back(predict_site_update(r));
  endtask

  task automatic quiesce();
    start <= 0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(pmsu_pkg::cfg_index_t idx, logic [7:0] value);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
    if (idx == pmsu_pkg::CFG_SPIN_COUNT) spin_count_copy = value;
    else zero_temp_copy = value[0];
    @(posedge clk);
  endtask

  function automatic site_request_t make_req(pmsu_pkg::mode_t m, int x, int y, int z, int us,
                                              int ua, int ti, int ld);
    site_request_t r;
    r.mode = m; r.x = 4'(x); r.y = 4'(y); r.z = 4'(z);
    r.u_spin = 16'(us); r.u_acc = 16'(ua); r.tidx = 5'(ti); r.load = 16'(ld);
    return r;
  endfunction

  // one of 15, 0, 1, 2, 3
  function automatic int rand_coord();
    return int'(4'($urandom_range(0, 4) + 15));
  endfunction

  function automatic site_request_t random_req(int update_weight);
    site_request_t r;
    int pick;
    r = make_req(pmsu_pkg::MODE_UPDATE, rand_coord(), rand_coord(), rand_coord(),
                 $urandom_range(0, 65535), $urandom_range(0, 65535),
                 $urandom_range(0, 31), $urandom_range(0, 65535));
    pick = $urandom_range(0, 99);
    if (pick >= update_weight) begin
      case ($urandom_range(0, 2))
        0: begin
          r.mode = pmsu_pkg::MODE_LOAD_SITE;
          // keep spins mostly small so neighborhoods stay mixed
          if ($urandom_range(0, 3) != 0) r.load[7:0] = 8'($urandom_range(1, 4));
        end
        1: r.mode = pmsu_pkg::MODE_LOAD_TABLE;
        default: r.mode = pmsu_pkg::MODE_NONE;
      endcase
    end
    return r;
  endfunction

  // every table entry and every site in the update neighborhoods written before anything reads them
  task automatic test_fill_state();
    gaps_on = 0;
    for (int t = 0; t < pmsu_pkg::TABLE_DEPTH; t++)
      send_request(make_req(pmsu_pkg::MODE_LOAD_TABLE, 0, 0, 0, 0, 0, t,
                            $urandom_range(0, 65535)));
    for (int i = 0; i < FILL_SPAN; i++)
      for (int j = 0; j < FILL_SPAN; j++)
        for (int k = 0; k < FILL_SPAN; k++)
          send_request(make_req(pmsu_pkg::MODE_LOAD_SITE, (i + 14) % 16, (j + 14) % 16,
                                (k + 14) % 16, 0, 0, 0, $urandom_range(1, 3)));
    gaps_on = 1;
  endtask

  task automatic test_directed();
    send_request(make_req(pmsu_pkg::MODE_UPDATE, 0, 0, 0, 0, 0, 0, 0));
    send_request(make_req(pmsu_pkg::MODE_UPDATE, 15, 15, 15, 16'hFFFF, 16'hFFFF, 31,
                          16'hFFFF));
    send_request(make_req(pmsu_pkg::MODE_UPDATE, 15, 0, 15, 16'h8000, 0, 0, 0));
    // equal proposal: site already 1, u=0 proposes 1
    send_request(make_req(pmsu_pkg::MODE_LOAD_SITE, 1, 2, 3, 0, 0, 0, 16'hFF01));
    send_request(make_req(pmsu_pkg::MODE_UPDATE, 1, 2, 3, 0, 16'hFFFF, 0, 0));
    // table index past the end is ignored
    send_request(make_req(pmsu_pkg::MODE_LOAD_TABLE, 0, 0, 0, 0, 0, 27, 16'hFFFF));
    send_request(make_req(pmsu_pkg::MODE_LOAD_TABLE, 0, 0, 0, 0, 0, 31, 16'h1234));
    send_request(make_req(pmsu_pkg::MODE_LOAD_TABLE, 0, 0, 0, 0, 0, 26, 16'hFFFF));
    send_request(make_req(pmsu_pkg::MODE_NONE, 15, 15, 15, 16'hFFFF, 16'hFFFF, 31,
                          16'hFFFF));
    send_request(make_req(pmsu_pkg::MODE_LOAD_SITE, 3, 3, 3, 0, 0, 0, 16'h00FF));
    send_request(make_req(pmsu_pkg::MODE_UPDATE, 3, 3, 3, 16'h0000, 16'h0000, 0, 0));
    send_request(make_req(pmsu_pkg::MODE_UPDATE, 3, 3, 2, 16'hFFFF, 16'h0000, 0, 0));
  endtask

  task automatic test_random_phase(int n, int update_weight);
    for (int i = 0; i < n; i++) send_request(random_req(update_weight));
  endtask

  task automatic test_config_sweep();
    quiesce();
    write_reg(pmsu_pkg::CFG_SPIN_COUNT, 8'd1);
    test_random_phase(80, 85);
    quiesce();
    write_reg(pmsu_pkg::CFG_SPIN_COUNT, 8'd255);
    test_random_phase(150, 80);
    quiesce();
    write_reg(pmsu_pkg::CFG_SPIN_COUNT, 8'd0);  // proposal clamps to zero
    test_random_phase(60, 85);
    quiesce();
    write_reg(pmsu_pkg::CFG_SPIN_COUNT, 8'd3);
    write_reg(pmsu_pkg::CFG_ZERO_TEMP, 8'd1);
    test_random_phase(200, 80);
    quiesce();
    write_reg(pmsu_pkg::CFG_ZERO_TEMP, 8'd0);
    write_reg(pmsu_pkg::CFG_SPIN_COUNT, 8'd4);
    test_random_phase(180, 80);
  endtask

  task automatic test_back_to_back();
    gaps_on = 0;
    test_random_phase(100, 80);
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with no request outstanding");
      end else begin
        site_outcome_t e;
        e = pending_results.pop_front();
        if (old_spin !== e.old_spin)
          report_mismatch($sformatf("old_spin %0d exp %0d", old_spin, e.old_spin));
        if (new_spin !== e.new_spin)
          report_mismatch($sformatf("new_spin %0d exp %0d", new_spin, e.new_spin));
        if (accepted !== e.accepted)
          report_mismatch($sformatf("accepted %0b exp %0b", accepted, e.accepted));
        if (energy_change !== e.energy_change)
          report_mismatch($sformatf("energy_change %0d exp %0d", energy_change,
                                    e.energy_change));
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("potts_metropolis_site_update_unit_test: FAIL");
      $finish;
    end
  end

  initial begin
    spin_count_copy = 8'd2;
    zero_temp_copy = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    test_fill_state();
    test_directed();
    test_random_phase(150, 80);
    test_config_sweep();
    test_back_to_back();
    quiesce();
    if (errors == 0) begin
      $display("potts_metropolis_site_update_unit_test: PASS");
    end else begin
      $display("potts_metropolis_site_update_unit_test: FAIL");
    end
    $finish;
  end
endmodule
